// ----- sv/sdpd_pkg.sv -----
// Shared types and protocol constants for the sensor data packet deframer.
`default_nettype none

package sdpd_pkg;

  // Frame bytes
  localparam logic [7:0] SYNC_BYTE0  = 8'hEF;
  localparam logic [7:0] SYNC_BYTE1  = 8'h01;
  localparam logic [7:0] ID_DATA     = 8'h02;
  localparam logic [7:0] ID_END      = 8'h08;
  localparam logic [7:0] ADDR_RESET  = 8'hFF;

  localparam int unsigned WIDX_W = 10;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic              result_kind;
    logic [7:0]        payload_byte;
    logic [WIDX_W-1:0] write_index;
    logic              checksum_ok;
    logic              final_packet;
    logic              overflow;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/sensor_data_packet_deframer_unit.sv -----
// A byte waits in the input register until parsed; any result it yields is registered.
// Throughput: one byte per cycle unless output stalls; parser step between two registers.
// Bytes that produce no result (header, id, length, sum high, dropped payload) leave nothing.
// Reset: asynchronous, active low; parser hunts for the first sync byte, counters clear,
// module address returns to all ones. No clearing pass; the block is ready right after reset.
`default_nettype none

module sensor_data_packet_deframer_unit import sdpd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Byte input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // Result output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [9:0]       write_index_o,
  output logic             checksum_ok_o,
  output logic             final_packet_o,
  output logic             overflow_o,
  // Configuration: module address
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  byte_q;
  logic [31:0] addr_q;
  logic        in_accept;
  logic        fire;
  logic        out_free;
  logic        res_vld;
  result_t     res;
  result_t     out_res;

  // Module address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= {4{ADDR_RESET}};
    end else if (cfg_we_i) begin
      addr_q <= cfg_wdata_i;
    end
  end

  // Parse the held byte whenever the result register can take whatever it yields
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Hold the byte until it is parsed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= rx_byte_i;
    end
  end

  sdpd_parser #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .rx_byte_i        (byte_q),
    .module_address_i (addr_q),
    .res_vld_o        (res_vld),
    .res_o            (res)
  );

  sdpd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_vld),
    .res_i   (res),
    .stall_i (out_stall_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign result_kind_o  = out_res.result_kind;
  assign payload_byte_o = out_res.payload_byte;
  assign write_index_o  = out_res.write_index;
  assign checksum_ok_o  = out_res.checksum_ok;
  assign final_packet_o = out_res.final_packet;
  assign overflow_o     = out_res.overflow;

endmodule

`default_nettype wire

// ----- sv/sdpd_parser.sv -----
// Frame parser: header hunt, id/length decode, payload indexing and checksum.
`default_nettype none

module sdpd_parser import sdpd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [31:0] module_address_i,
  output logic             res_vld_o,
  output result_t          res_o
);

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned EXT_W = (IDX_W > WIDX_W) ? IDX_W : WIDX_W;

  typedef enum logic [11:0] {
    PH_HUNT  = 12'b0000_0000_0001,
    PH_SYNC2 = 12'b0000_0000_0010,
    PH_ADDR0 = 12'b0000_0000_0100,
    PH_ADDR1 = 12'b0000_0000_1000,
    PH_ADDR2 = 12'b0000_0001_0000,
    PH_ADDR3 = 12'b0000_0010_0000,
    PH_ID    = 12'b0000_0100_0000,
    PH_LENHI = 12'b0000_1000_0000,
    PH_LENLO = 12'b0001_0000_0000,
    PH_DATA  = 12'b0010_0000_0000,
    PH_SUMHI = 12'b0100_0000_0000,
    PH_SUMLO = 12'b1000_0000_0000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [15:0]       remain_q, remain_d;
  logic [15:0]       sum_q, sum_d;
  logic [7:0]        sum_hi_q, sum_hi_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              end_seen_q, end_seen_d;
  logic              ovf_seen_q, ovf_seen_d;

  logic [15:0]       len_full;
  logic [15:0]       remain_dec;
  logic [EXT_W-1:0]  idx_ext;
  phase_e            restart;

  assign len_full   = {len_hi_q, rx_byte_i};
  assign remain_dec = remain_q - 16'd1;
  assign idx_ext    = EXT_W'(idx_q);
  assign restart    = (rx_byte_i == SYNC_BYTE0) ? PH_SYNC2 : PH_HUNT;

  always_comb begin
    phase_d    = phase_q;
    len_hi_d   = len_hi_q;
    remain_d   = remain_q;
    sum_d      = sum_q;
    sum_hi_d   = sum_hi_q;
    idx_d      = idx_q;
    end_seen_d = end_seen_q;
    ovf_seen_d = ovf_seen_q;
    res_vld_o  = 1'b0;
    res_o      = '0;

    unique case (phase_q)
      PH_HUNT:  phase_d = restart;
      PH_SYNC2: phase_d = (rx_byte_i == SYNC_BYTE1) ? PH_ADDR0 : restart;
      PH_ADDR0: phase_d = (rx_byte_i == module_address_i[31:24]) ? PH_ADDR1 : restart;
      PH_ADDR1: phase_d = (rx_byte_i == module_address_i[23:16]) ? PH_ADDR2 : restart;
      PH_ADDR2: phase_d = (rx_byte_i == module_address_i[15:8])  ? PH_ADDR3 : restart;
      PH_ADDR3: phase_d = (rx_byte_i == module_address_i[7:0])   ? PH_ID    : restart;
      PH_ID: begin
        if (rx_byte_i == ID_DATA || rx_byte_i == ID_END) begin
          end_seen_d = (rx_byte_i == ID_END);
          sum_d      = {8'd0, rx_byte_i};
          phase_d    = PH_LENHI;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_LENHI: begin
        len_hi_d = rx_byte_i;
        sum_d    = sum_q + {8'd0, rx_byte_i};
        phase_d  = PH_LENLO;
      end
      PH_LENLO: begin
        sum_d    = sum_q + {8'd0, rx_byte_i};
        remain_d = (len_full >= 16'd2) ? (len_full - 16'd2) : 16'd0;
        phase_d  = (len_full > 16'd2) ? PH_DATA : PH_SUMHI;
      end
      PH_DATA: begin
        sum_d    = sum_q + {8'd0, rx_byte_i};
        remain_d = remain_dec;
        if (idx_q < IDX_W'(STORE_DEPTH)) begin
          res_vld_o          = 1'b1;
          res_o.result_kind  = KIND_PAYLOAD;
          res_o.payload_byte = rx_byte_i;
          res_o.write_index  = idx_ext[WIDX_W-1:0];
          res_o.overflow     = ovf_seen_q;
          idx_d              = idx_q + IDX_W'(1);
        end else begin
          ovf_seen_d = 1'b1;
        end
        if (remain_dec == 16'd0) begin
          phase_d = PH_SUMHI;
        end
      end
      PH_SUMHI: begin
        sum_hi_d = rx_byte_i;
        phase_d  = PH_SUMLO;
      end
      PH_SUMLO: begin
        res_vld_o          = 1'b1;
        res_o.result_kind  = KIND_STATUS;
        res_o.checksum_ok  = ({sum_hi_q, rx_byte_i} == sum_q);
        res_o.final_packet = end_seen_q;
        res_o.overflow     = ovf_seen_q;
        if (end_seen_q) begin
          idx_d      = '0;
          ovf_seen_d = 1'b0;
        end
        end_seen_d = 1'b0;
        phase_d    = PH_HUNT;
      end
      default: phase_d = restart;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      len_hi_q   <= '0;
      remain_q   <= '0;
      sum_q      <= '0;
      sum_hi_q   <= '0;
      idx_q      <= '0;
      end_seen_q <= 1'b0;
      ovf_seen_q <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      len_hi_q   <= len_hi_d;
      remain_q   <= remain_d;
      sum_q      <= sum_d;
      sum_hi_q   <= sum_hi_d;
      idx_q      <= idx_d;
      end_seen_q <= end_seen_d;
      ovf_seen_q <= ovf_seen_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sdpd_out_stage.sv -----
// Result register between the parser and the output channel.
`default_nettype none

module sdpd_out_stage import sdpd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire result_t  res_i,
  input  wire logic     stall_i,
  output logic          free_o,
  output logic          valid_o,
  output result_t       res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  // Register can take a new result when empty or when its content leaves now
  assign free_o = !vld_q || !stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (vld_q && !stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the sensor data packet deframer unit.
`timescale 1ns / 100ps

module tb import sdpd_pkg::*; ();

  localparam int unsigned STORE_DEPTH = 1024;

  // Parser position, one step per received byte
  typedef enum logic [3:0] {
    HUNT_SYNC0, WAIT_SYNC1, ADDR_B0, ADDR_B1, ADDR_B2, ADDR_B3,
    READ_ID, LEN_HI, LEN_LO, PAYLOAD, SUM_HI, SUM_LO
  } frame_state_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [7:0]  payload_byte_o;
  logic [9:0]  write_index_o;
  logic        checksum_ok_o;
  logic        final_packet_o;
  logic        overflow_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = 32'h0;

  sensor_data_packet_deframer_unit #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .write_index_o  (write_index_o),
    .checksum_ok_o  (checksum_ok_o),
    .final_packet_o (final_packet_o),
    .overflow_o     (overflow_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes waiting to go out on the link, and deframer results still owed by the DUT
  logic [7:0]  link_bytes [$];
  result_t     due_results [$];

  // Shadow of the module address register; also used to build headers
  logic [31:0] module_addr = 32'hFFFF_FFFF;

  // Shadow parser state
  frame_state_e parse_state = HUNT_SYNC0;
  logic [15:0]  frame_len = '0;
  logic [15:0]  bytes_left = '0;
  logic [15:0]  frame_sum = '0;
  logic [7:0]   sum_hi = '0;
  logic [10:0]  store_fill = '0;
  logic         is_end_packet = 1'b0;
  logic         store_overflowed = 1'b0;

  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned payload_checked = 0;
  int unsigned status_checked = 0;
  int unsigned overflow_reports = 0;
  int unsigned bad_sum_reports = 0;
  int unsigned addr_settings = 1;
  int unsigned mismatch_count = 0;

  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  // Draw a per-transfer wait; flip between idle-heavy and back-to-back stretches
  function automatic int unsigned draw_wait(inout bit steady);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  // On a header mismatch, a stray sync byte still counts as a fresh header start
  function automatic frame_state_e resync(input logic [7:0] b);
    return (b == SYNC_BYTE0) ? WAIT_SYNC1 : HUNT_SYNC0;
  endfunction

  // Advance the shadow parser by one byte and queue whatever result it owes
  function automatic void deframe_byte(input logic [7:0] b);
    result_t     r;
    logic [7:0]  addr_byte;
    r = '0;
    case (parse_state)
      HUNT_SYNC0: parse_state = resync(b);
      WAIT_SYNC1: parse_state = (b == SYNC_BYTE1) ? ADDR_B0 : resync(b);
      ADDR_B0, ADDR_B1, ADDR_B2, ADDR_B3: begin
        // address goes out most significant byte first
        addr_byte = 8'(module_addr >> (8 * (ADDR_B3 - parse_state)));
        parse_state = (b == addr_byte) ? frame_state_e'(parse_state + 1) : resync(b);
      end
      READ_ID: begin
        if (b == ID_DATA || b == ID_END) begin
          is_end_packet = (b == ID_END);
          frame_sum = {8'h00, b};
          parse_state = LEN_HI;
        end else begin
          // unknown packet kind: drop it and hunt again from the next byte
          parse_state = HUNT_SYNC0;
        end
      end
      LEN_HI: begin
        frame_len = {b, 8'h00};
        frame_sum = frame_sum + b;
        parse_state = LEN_LO;
      end
      LEN_LO: begin
        frame_len[7:0] = b;
        frame_sum = frame_sum + b;
        // the length counts the two sum bytes; anything shorter means no payload
        bytes_left = (frame_len >= 16'd2) ? frame_len - 16'd2 : 16'd0;
        parse_state = (bytes_left != 0) ? PAYLOAD : SUM_HI;
      end
      PAYLOAD: begin
        frame_sum = frame_sum + b;
        if (store_fill < STORE_DEPTH) begin
          r.result_kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.write_index = store_fill[9:0];
          r.overflow = store_overflowed;
          due_results.push_back(r);
          store_fill = store_fill + 1'b1;
        end else begin
          // store full: drop the byte, hold the index, remember the loss
          store_overflowed = 1'b1;
        end
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) parse_state = SUM_HI;
      end
      SUM_HI: begin
        sum_hi = b;
        parse_state = SUM_LO;
      end
      SUM_LO: begin
        r.result_kind = KIND_STATUS;
        r.checksum_ok = ({sum_hi, b} == frame_sum);
        r.final_packet = is_end_packet;
        r.overflow = store_overflowed;
        due_results.push_back(r);
        // an end packet closes the transfer; the next one starts at index zero
        if (is_end_packet) begin
          store_fill = '0;
          store_overflowed = 1'b0;
        end
        is_end_packet = 1'b0;
        parse_state = HUNT_SYNC0;
      end
      default: parse_state = resync(b);
    endcase
  endfunction

  // Sender: hold the byte while stalled, insert random gaps between transfers
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(rx_byte_i);
        bytes_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (link_bytes.size() != 0) begin
          rx_byte_i <= link_bytes.pop_front();
          in_valid_i <= 1'b1;
          send_wait = draw_wait(send_steady);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {result_kind_o, payload_byte_o, write_index_o, checksum_ok_o,
               final_packet_o, overflow_o};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          compare_field("result_kind", want.result_kind, got.result_kind);
          compare_field("payload_byte", want.payload_byte, got.payload_byte);
          compare_field("write_index", want.write_index, got.write_index);
          compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
          compare_field("final_packet", want.final_packet, got.final_packet);
          compare_field("overflow", want.overflow, got.overflow);
        end
        if (got.result_kind == KIND_STATUS) begin
          status_checked++;
          if (got.overflow) overflow_reports++;
          if (!got.checksum_ok) bad_sum_reports++;
        end else begin
          payload_checked++;
        end
        recv_wait = draw_wait(recv_steady);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_header();
    queue_byte(SYNC_BYTE0);
    queue_byte(SYNC_BYTE1);
    queue_byte(module_addr[31:24]);
    queue_byte(module_addr[23:16]);
    queue_byte(module_addr[15:8]);
    queue_byte(module_addr[7:0]);
  endtask

  // Queue a full packet with random payload; optionally corrupt one sum bit
  task automatic queue_packet(input logic [7:0] id, input logic [15:0] len,
                              input bit good_sum);
    logic [15:0] sum;
    logic [7:0]  d;
    int unsigned n;
    queue_header();
    queue_byte(id);
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
    sum = id + len[15:8] + len[7:0];
    n = (len >= 16'd2) ? len - 16'd2 : 0;
    repeat (n) begin
      d = 8'($urandom);
      queue_byte(d);
      sum = sum + d;
    end
    if (!good_sum) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    queue_byte(sum[15:8]);
    queue_byte(sum[7:0]);
  endtask

  task automatic queue_unknown_id();
    logic [7:0] id;
    queue_header();
    do id = 8'($urandom); while (id == ID_DATA || id == ID_END);
    queue_byte(id);
  endtask

  // Cut a header short with a byte that does not fit
  task automatic queue_broken_header();
    logic [7:0]  hdr [6];
    logic [7:0]  wrong;
    int unsigned cut;
    hdr = '{SYNC_BYTE0, SYNC_BYTE1, module_addr[31:24], module_addr[23:16],
            module_addr[15:8], module_addr[7:0]};
    cut = $urandom_range(1, 5);
    for (int i = 0; i < cut; i++) queue_byte(hdr[i]);
    wrong = 8'($urandom);
    if (wrong == hdr[cut]) wrong = wrong ^ 8'h40;
    queue_byte(wrong);
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) == 0) queue_byte(SYNC_BYTE0);
      else queue_byte(8'($urandom));
    end
  endtask

  // Mostly well-formed packets with random content, some junk mixed in
  task automatic queue_random_traffic(input int unsigned budget);
    int unsigned goal;
    int unsigned pick;
    logic [15:0] len;
    goal = bytes_queued + budget;
    while (bytes_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) len = 16'($urandom_range(0, 1));
        else if (pick < 95) len = 16'($urandom_range(2, 24));
        else len = 16'($urandom_range(25, 80));
        queue_packet(($urandom_range(0, 4) == 0) ? ID_END : ID_DATA, len,
                     $urandom_range(0, 7) != 0);
      end else if (pick < 85) begin
        queue_unknown_id();
      end else if (pick < 95) begin
        queue_broken_header();
      end else begin
        queue_noise();
      end
    end
  endtask

  // Push one transfer just past the store size so that payload gets dropped
  task automatic queue_overflow_transfer();
    int unsigned total;
    logic [15:0] len;
    total = 0;
    while (total <= STORE_DEPTH) begin
      len = 16'($urandom_range(515, 518));
      queue_packet(ID_DATA, len, 1'b1);
      total += len - 16'd2;
    end
    queue_packet(ID_END, 16'd6, 1'b1);
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    while (link_bytes.size() != 0 || in_valid_i || due_results.size() != 0)
      @(negedge clk_i);
    // let trailing bytes that owe no result clear the parser
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_module_address(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    module_addr = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    addr_settings++;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stray sync byte before a header, data packet, unknown id,
    // end packet with a short length and a wrong sum
    queue_byte(SYNC_BYTE0);
    queue_packet(ID_DATA, 16'd4, 1'b1);
    queue_unknown_id();
    queue_packet(ID_END, 16'd1, 1'b0);
    wait_until_drained();

    queue_overflow_transfer();
    wait_until_drained();

    write_module_address(32'h0000_0000);
    queue_random_traffic(8);
    wait_until_drained();

    // address bytes that look like sync bytes stress the restart logic
    write_module_address({SYNC_BYTE0, SYNC_BYTE1, SYNC_BYTE0, SYNC_BYTE1});
    queue_random_traffic(8);
    wait_until_drained();

    write_module_address($urandom);
    queue_random_traffic(8);
    wait_until_drained();

    write_module_address(32'hFFFF_FFFF);
    queue_random_traffic(8);
    wait_until_drained();

    write_module_address($urandom);
    queue_random_traffic(8);
    wait_until_drained();

    repeat (4) @(posedge clk_i);
    $display("Ran %0d link bytes under %0d address settings; checked %0d payload bytes",
             bytes_accepted, addr_settings, payload_checked);
    $display("and %0d packet status results (%0d with lost payload, %0d with a bad sum)",
             status_checked, overflow_reports, bad_sum_reports);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: bail out if the handshakes stop moving
  initial begin
    #4_000_000;
    $display("%0t: timeout with %0d results still owed", $time, due_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
